### rtl/core/mspc_pkg.sv
// ----------------------------------------------------------------------------
// mspc_pkg
// types and constants shared by the microslice pattern checker modules
// ----------------------------------------------------------------------------
package mspc_pkg;

    localparam int unsigned IndexWidth   = 64;
    localparam int unsigned SizeWidth    = 32;
    localparam int unsigned CksWidth     = 32;
    localparam int unsigned SysIdWidth   = 8;
    localparam int unsigned CompWidth    = 16;
    localparam int unsigned WordWidth    = 64;
    localparam int unsigned CountWidth   = 32;
    localparam int unsigned BytesWidth   = 48;
    localparam int unsigned WordsWidth   = 29;
    localparam int unsigned OffsetWidth  = 32;
    localparam int unsigned PaddrWidth   = 3;
    localparam int unsigned PdataWidth   = 32;

    localparam logic [SysIdWidth-1:0] PATTERN_ID_RESET = 8'hFA;
    localparam logic [CountWidth-1:0] COUNT_MAX        = 32'hFFFF_FFFF;
    localparam logic [BytesWidth-1:0] BYTES_MAX        = 48'hFFFF_FFFF_FFFF;
    localparam logic [OffsetWidth-1:0] OFFSET_STEP     = 32'd8;

    typedef enum logic {
        KIND_DESC = 1'b0,
        KIND_WORD = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_INDEX    = 2'd1,
        ERR_WORD     = 2'd2,
        ERR_CHECKSUM = 2'd3
    } t_err;

    typedef struct packed {
        t_kind                  kind;
        logic [IndexWidth-1:0]  desc_index;
        logic [IndexWidth-1:0]  expected_index;
        logic [SizeWidth-1:0]   size_bytes;
        logic [CksWidth-1:0]    desc_checksum;
        logic [SysIdWidth-1:0]  system_id;
        logic [CompWidth-1:0]   component;
        logic [WordWidth-1:0]   slice_word;
    } t_item;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_stage_ctrl;

endpackage

### rtl/core/microslice_pattern_checker_unit.sv
// ----------------------------------------------------------------------------
// microslice_pattern_checker_unit
// checks descriptor and data words of a microslice stream against the test
// pattern, reports one verdict per microslice with running totals
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   i_kind .. i_slice_word
//   out       source     o_out_valid / i_out_stall o_passed .. o_byte_total
//   cfg       sink       psel penable pwrite       paddr pwdata prdata pready
//
// one word per cycle while the result is not stalled: input register, check
// logic, result register; a verdict is offered from the result register
// synchronous active-low reset clears state, counters and valid flags, the
// pattern id returns to 0xfa
// a stalled result holds the check stage; input stall follows it in the same
// cycle, so a full pipeline keeps moving while the result is being taken
// ----------------------------------------------------------------------------
module microslice_pattern_checker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [mspc_pkg::IndexWidth-1:0]     i_desc_index,
    input  logic [mspc_pkg::IndexWidth-1:0]     i_expected_index,
    input  logic [mspc_pkg::SizeWidth-1:0]      i_size_bytes,
    input  logic [mspc_pkg::CksWidth-1:0]       i_desc_checksum,
    input  logic [mspc_pkg::SysIdWidth-1:0]     i_system_id,
    input  logic [mspc_pkg::CompWidth-1:0]      i_component,
    input  logic [mspc_pkg::WordWidth-1:0]      i_slice_word,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_passed,
    output logic [1:0]                          o_error_code,
    output logic [mspc_pkg::CountWidth-1:0]     o_microslice_total,
    output logic [mspc_pkg::BytesWidth-1:0]     o_byte_total,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mspc_pkg::PaddrWidth-1:0]     paddr,
    input  logic [mspc_pkg::PdataWidth-1:0]     pwdata,
    output logic [mspc_pkg::PdataWidth-1:0]     prdata,
    output logic                                pready
);

    logic                               r_in_valid;
    mspc_pkg::t_item                    r_item;
    mspc_pkg::t_stage_ctrl              core_in;
    mspc_pkg::t_stage_ctrl              core_out;
    logic [mspc_pkg::SysIdWidth-1:0]    pattern_id;
    logic                               in_accept;
    logic                               core_take;

    assign core_take  = r_in_valid && core_out.ready;
    assign o_in_stall = r_in_valid && !core_out.ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (core_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.kind           <= mspc_pkg::t_kind'(i_kind);
            r_item.desc_index     <= i_desc_index;
            r_item.expected_index <= i_expected_index;
            r_item.size_bytes     <= i_size_bytes;
            r_item.desc_checksum  <= i_desc_checksum;
            r_item.system_id      <= i_system_id;
            r_item.component      <= i_component;
            r_item.slice_word     <= i_slice_word;
        end
    end

    assign core_in.valid = r_in_valid;
    assign core_in.ready = 1'b1;

    mspc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_pattern_id (pattern_id)
    );

    mspc_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl_in          (core_in),
        .o_ctrl_out         (core_out),
        .i_item             (r_item),
        .i_pattern_id       (pattern_id),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_passed           (o_passed),
        .o_error_code       (o_error_code),
        .o_microslice_total (o_microslice_total),
        .o_byte_total       (o_byte_total)
    );

endmodule

### rtl/core/mspc_cfg.sv
// ----------------------------------------------------------------------------
// mspc_cfg
// register port holding the pattern system id
// ----------------------------------------------------------------------------
module mspc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mspc_pkg::PaddrWidth-1:0]     paddr,
    input  logic [mspc_pkg::PdataWidth-1:0]     pwdata,
    output logic [mspc_pkg::PdataWidth-1:0]     prdata,
    output logic                                pready,
    output logic [mspc_pkg::SysIdWidth-1:0]     o_pattern_id
);

    logic                               sel_pattern;
    logic [mspc_pkg::SysIdWidth-1:0]    r_pattern_id;

    // register 0 occupies byte addresses 0 to 3
    assign sel_pattern = (paddr[mspc_pkg::PaddrWidth-1] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_id <= mspc_pkg::PATTERN_ID_RESET;
        end else if (psel && penable && pwrite && sel_pattern) begin
            r_pattern_id <= pwdata[mspc_pkg::SysIdWidth-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_pattern) begin
            prdata[mspc_pkg::SysIdWidth-1:0] = r_pattern_id;
        end
    end

    assign pready       = 1'b1;
    assign o_pattern_id = r_pattern_id;

endmodule

### rtl/core/mspc_core.sv
// ----------------------------------------------------------------------------
// mspc_core
// microslice state, per-item check logic and result register
// ----------------------------------------------------------------------------
module mspc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mspc_pkg::t_stage_ctrl               i_ctrl_in,
    output mspc_pkg::t_stage_ctrl               o_ctrl_out,
    input  mspc_pkg::t_item                     i_item,
    input  logic [mspc_pkg::SysIdWidth-1:0]     i_pattern_id,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_passed,
    output logic [1:0]                          o_error_code,
    output logic [mspc_pkg::CountWidth-1:0]     o_microslice_total,
    output logic [mspc_pkg::BytesWidth-1:0]     o_byte_total
);

    logic [mspc_pkg::WordsWidth-1:0]    r_words_rem, n_words_rem;
    logic [mspc_pkg::OffsetWidth-1:0]   r_offset, n_offset;
    logic                               r_active, n_active;
    logic [mspc_pkg::CompWidth-1:0]     r_comp, n_comp;
    logic [mspc_pkg::CksWidth-1:0]      r_cks, n_cks;
    logic [mspc_pkg::CksWidth-1:0]      r_fold, n_fold;
    mspc_pkg::t_err                     r_first_err, n_first_err;
    logic [mspc_pkg::CountWidth-1:0]    r_slices, n_slices;
    logic [mspc_pkg::BytesWidth-1:0]    r_bytes, n_bytes;

    logic                               r_out_valid;
    logic                               r_passed;
    mspc_pkg::t_err                     r_err;
    logic [mspc_pkg::CountWidth-1:0]    r_slices_out;
    logic [mspc_pkg::BytesWidth-1:0]    r_bytes_out;

    logic                               out_free;
    logic                               advance;
    logic                               emit;
    mspc_pkg::t_err                     emit_err;
    logic [mspc_pkg::BytesWidth:0]      byte_sum;
    logic [mspc_pkg::WordsWidth-1:0]    words_dec;
    logic [mspc_pkg::WordWidth-1:0]     expect_word;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = i_ctrl_in.valid && out_free;

    assign o_ctrl_out.valid = r_out_valid;
    assign o_ctrl_out.ready = out_free;

    assign byte_sum    = {1'b0, r_bytes}
                       + {{(mspc_pkg::BytesWidth + 1 - mspc_pkg::SizeWidth){1'b0}},
                          i_item.size_bytes};
    assign words_dec   = r_words_rem - 1'b1;
    assign expect_word = {r_comp,
                          {(mspc_pkg::WordWidth - mspc_pkg::CompWidth
                            - mspc_pkg::OffsetWidth){1'b0}},
                          r_offset};

    always_comb begin
        n_words_rem = r_words_rem;
        n_offset    = r_offset;
        n_active    = r_active;
        n_comp      = r_comp;
        n_cks       = r_cks;
        n_fold      = r_fold;
        n_first_err = r_first_err;
        n_slices    = r_slices;
        n_bytes     = r_bytes;
        emit        = 1'b0;
        emit_err    = mspc_pkg::ERR_NONE;

        case (i_item.kind)
            mspc_pkg::KIND_DESC: begin
                n_words_rem = i_item.size_bytes[mspc_pkg::SizeWidth-1:3];
                n_offset    = '0;
                n_active    = 1'b0;
                n_fold      = '0;
                n_first_err = mspc_pkg::ERR_NONE;
                if (i_item.desc_index != i_item.expected_index) begin
                    emit     = 1'b1;
                    emit_err = mspc_pkg::ERR_INDEX;
                end else begin
                    if (r_slices != mspc_pkg::COUNT_MAX) begin
                        n_slices = r_slices + 1'b1;
                    end
                    n_bytes = byte_sum[mspc_pkg::BytesWidth] ? mspc_pkg::BYTES_MAX
                                                             : byte_sum[mspc_pkg::BytesWidth-1:0];
                    if (i_item.system_id != i_pattern_id) begin
                        emit     = 1'b1;
                        emit_err = mspc_pkg::ERR_NONE;
                    end else begin
                        n_comp = i_item.component;
                        n_cks  = i_item.desc_checksum;
                        if (i_item.size_bytes[mspc_pkg::SizeWidth-1:3] == '0) begin
                            emit     = 1'b1;
                            emit_err = (i_item.desc_checksum == '0) ? mspc_pkg::ERR_NONE
                                                                    : mspc_pkg::ERR_CHECKSUM;
                        end else begin
                            n_active = 1'b1;
                        end
                    end
                end
            end
            mspc_pkg::KIND_WORD: begin
                if (r_words_rem != '0) begin
                    n_words_rem = words_dec;
                    if (r_active) begin
                        n_fold = r_fold
                               ^ i_item.slice_word[mspc_pkg::CksWidth-1:0]
                               ^ i_item.slice_word[mspc_pkg::WordWidth-1:mspc_pkg::CksWidth];
                        if ((i_item.slice_word != expect_word)
                                && (r_first_err == mspc_pkg::ERR_NONE)) begin
                            n_first_err = mspc_pkg::ERR_WORD;
                        end
                        n_offset = r_offset + mspc_pkg::OFFSET_STEP;
                        if (words_dec == '0) begin
                            n_active = 1'b0;
                            emit     = 1'b1;
                            if (n_first_err != mspc_pkg::ERR_NONE) begin
                                emit_err = n_first_err;
                            end else begin
                                emit_err = (n_fold == r_cks) ? mspc_pkg::ERR_NONE
                                                             : mspc_pkg::ERR_CHECKSUM;
                            end
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_rem <= '0;
            r_offset    <= '0;
            r_active    <= 1'b0;
            r_comp      <= '0;
            r_cks       <= '0;
            r_fold      <= '0;
            r_first_err <= mspc_pkg::ERR_NONE;
            r_slices    <= '0;
            r_bytes     <= '0;
        end else if (advance) begin
            r_words_rem <= n_words_rem;
            r_offset    <= n_offset;
            r_active    <= n_active;
            r_comp      <= n_comp;
            r_cks       <= n_cks;
            r_fold      <= n_fold;
            r_first_err <= n_first_err;
            r_slices    <= n_slices;
            r_bytes     <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded only when a verdict is produced
    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_passed     <= (emit_err == mspc_pkg::ERR_NONE);
            r_err        <= emit_err;
            r_slices_out <= n_slices;
            r_bytes_out  <= n_bytes;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_passed           = r_passed;
    assign o_error_code       = r_err;
    assign o_microslice_total = r_slices_out;
    assign o_byte_total       = r_bytes_out;

endmodule
